@@ design/qnorm_pkg.sv @@
// qnorm_pkg: shared widths, codes and reset values for the quaternion
// normalize unit. No dependencies.
package qnorm_pkg;
  localparam int CompW  = 24;
  localparam int OutW   = 16;
  localparam int SqW    = 2 * CompW - 1;
  localparam int SumW   = SqW + 2;
  localparam int AccW   = 82;
  localparam int NBits  = 15;
  localparam int Lanes  = 4;
  localparam int FracSh = 30;
  localparam int IdxW   = 8;
  localparam logic [CompW-1:0] LowReset  = 24'd41;
  localparam logic [CompW-1:0] HighReset = 24'd409600;
  localparam logic [OutW-1:0]  OneQ14    = 16'd16384;
  typedef enum logic [IdxW-1:0] {
    REG_LOW  = 8'd0,
    REG_HIGH = 8'd1
  } reg_idx_e;
  typedef logic signed [AccW-1:0] acc_t;
endpackage

@@ design/qnorm_cell.sv @@
// qnorm_cell: one bit of the restoring scaled divide for one component.
// Depends on qnorm_pkg.
module qnorm_cell #(
  parameter int K = 0
) (
  input  logic                            clk_i,
  input  qnorm_pkg::acc_t                 p_i,
  input  qnorm_pkg::acc_t                 q_i,
  input  qnorm_pkg::acc_t                 s_i,
  input  qnorm_pkg::acc_t                 r_i,
  input  logic [qnorm_pkg::NBits-1:0]     n_i,
  output qnorm_pkg::acc_t                 p_o,
  output qnorm_pkg::acc_t                 q_o,
  output qnorm_pkg::acc_t                 s_o,
  output qnorm_pkg::acc_t                 r_o,
  output logic [qnorm_pkg::NBits-1:0]     n_o
);
  import qnorm_pkg::*;
  acc_t cand, p_d, q_d;
  logic [NBits-1:0] n_d;
  logic take;
  // (m + 2^(K+1))^2 S = m^2 S + 2^(K+2) m S + 2^(2K+2) S
  always_comb begin
    cand = p_i + (q_i <<< (K + 2)) + (s_i <<< (2 * K + 2));
    take = (cand <= r_i);
    p_d  = take ? cand : p_i;
    q_d  = take ? (q_i + (s_i <<< (K + 1))) : q_i;
    n_d  = n_i | (NBits'(take) << K);
  end
  always_ff @(posedge clk_i) begin
    p_o <= p_d;
    q_o <= q_d;
    s_o <= s_i;
    r_o <= r_i;
    n_o <= n_d;
  end
endmodule

@@ design/quaternion_normalize_unit.sv @@
// quaternion_normalize_unit: top level, squares, range check, a row of
// divide cells per component and the output register. Depends on qnorm_pkg
// and qnorm_cell.
//
// A quaternion is taken every cycle (busy_o stays low); its result shows on
// done_o after it has passed every pipeline stage in turn: a square stage,
// a sum and limit-compare stage, fifteen divide cells (one result bit each)
// and the output register. done_o lasts one cycle and cannot be held off.
// The configuration port is always ready.
module quaternion_normalize_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [qnorm_pkg::CompW-1:0] q_w_i,
  input  logic signed [qnorm_pkg::CompW-1:0] q_x_i,
  input  logic signed [qnorm_pkg::CompW-1:0] q_y_i,
  input  logic signed [qnorm_pkg::CompW-1:0] q_z_i,
  output logic                              done_o,
  output logic signed [qnorm_pkg::OutW-1:0]  n_w_o,
  output logic signed [qnorm_pkg::OutW-1:0]  n_x_o,
  output logic signed [qnorm_pkg::OutW-1:0]  n_y_o,
  output logic signed [qnorm_pkg::OutW-1:0]  n_z_o,
  output logic                              fell_back_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qnorm_pkg::IdxW-1:0]         cfg_index_i,
  input  logic [qnorm_pkg::CompW-1:0]        cfg_data_i
);
  import qnorm_pkg::*;
  localparam int Stages = NBits + 1;

  logic [CompW-1:0] low_q, high_q;
  logic [SqW:0]     low2_q, high2_q;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowReset;
      high_q <= HighReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW:  low_q  <= cfg_data_i;
        REG_HIGH: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk_i) begin
    low2_q  <= (SqW+1)'(low_q) * (SqW+1)'(low_q);
    high2_q <= (SqW+1)'(high_q) * (SqW+1)'(high_q);
  end

  logic signed [CompW-1:0] comp [Lanes];
  assign comp[0] = q_w_i;
  assign comp[1] = q_x_i;
  assign comp[2] = q_y_i;
  assign comp[3] = q_z_i;

  // stage 1: magnitudes squared
  logic [SqW-1:0]   sq_q [Lanes];
  logic [Lanes-1:0] neg1_q;
  logic             v1_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      logic [CompW-1:0] mag;
      mag       = comp[i][CompW-1] ? (~comp[i] + 1'b1) : comp[i];
      sq_q[i]   <= SqW'({{(SqW-CompW){1'b0}}, mag} * {{(SqW-CompW){1'b0}}, mag});
      neg1_q[i] <= comp[i][CompW-1];
    end
  end

  // stage 2: sum and limit compare
  logic [SumW-1:0] s_sum;
  always_comb begin
    s_sum = '0;
    for (int i = 0; i < Lanes; i++) s_sum = s_sum + SumW'(sq_q[i]);
  end

  acc_t             p_a [Stages][Lanes];
  acc_t             q_a [Stages][Lanes];
  acc_t             s_a [Stages][Lanes];
  acc_t             r_a [Stages][Lanes];
  logic [NBits-1:0] n_a [Stages][Lanes];
  logic [Lanes-1:0] neg_q [Stages];
  logic             ok_q  [Stages];
  logic             v_q   [Stages];

  always_ff @(posedge clk_i) begin
    ok_q[0]  <= (AccW'(s_sum) > AccW'(low2_q)) && (AccW'(s_sum) < AccW'(high2_q));
    neg_q[0] <= neg1_q;
    for (int i = 0; i < Lanes; i++) begin
      p_a[0][i] <= acc_t'(s_sum);
      q_a[0][i] <= -acc_t'(s_sum);
      s_a[0][i] <= acc_t'(s_sum);
      r_a[0][i] <= acc_t'(sq_q[i]) <<< FracSh;
      n_a[0][i] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int j = 0; j < Stages; j++) v_q[j] <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v_q[0] <= v1_q;
      for (int j = 1; j < Stages; j++) v_q[j] <= v_q[j-1];
    end
  end

  for (genvar j = 1; j < Stages; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      neg_q[j] <= neg_q[j-1];
      ok_q[j]  <= ok_q[j-1];
    end
    for (genvar i = 0; i < Lanes; i++) begin : g_lane
      qnorm_cell #(.K(NBits - j)) u_cell (
        .clk_i (clk_i),
        .p_i   (p_a[j-1][i]), .q_i (q_a[j-1][i]), .s_i (s_a[j-1][i]),
        .r_i   (r_a[j-1][i]), .n_i (n_a[j-1][i]),
        .p_o   (p_a[j][i]),   .q_o (q_a[j][i]),   .s_o (s_a[j][i]),
        .r_o   (r_a[j][i]),   .n_o (n_a[j][i])
      );
    end
  end

  logic [OutW-1:0] res [Lanes];
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      logic [OutW-1:0] nv;
      nv     = OutW'(n_a[Stages-1][i]);
      res[i] = neg_q[Stages-1][i] ? (~nv + 1'b1) : nv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= v_q[Stages-1];
  end
  always_ff @(posedge clk_i) begin
    fell_back_o <= !ok_q[Stages-1];
    n_w_o <= ok_q[Stages-1] ? res[0] : OneQ14;
    n_x_o <= ok_q[Stages-1] ? res[1] : '0;
    n_y_o <= ok_q[Stages-1] ? res[2] : '0;
    n_z_o <= ok_q[Stages-1] ? res[3] : '0;
  end
endmodule
